@@ rtl/bdadj_pkg.sv @@
// ----------------------------------------------------------------------------
// bdadj_pkg
// Shared widths, codes, the digit pattern table and the display drive type
// for the button duty adjust unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdadj_pkg;

    localparam int DutyW    = 8;
    localparam int PctW     = 7;
    localparam int SegW     = 8;
    localparam int DenW     = 2;
    localparam int DigitW   = 4;
    localparam int InDataW  = 8;
    localparam int OutDataW = 32;

    localparam logic [DutyW-1:0] DebounceReset = 8'd6;
    localparam logic [DutyW-1:0] DutyMax       = 8'd255;
    localparam logic [DutyW-1:0] DutyMin       = 8'd0;

    localparam logic KindPoll = 1'b0;
    localparam logic KindTick = 1'b1;

    localparam logic [DenW-1:0] DenTens  = 2'd1;
    localparam logic [DenW-1:0] DenUnits = 2'd2;

    typedef struct packed {
        logic [PctW-1:0] percent;
        logic [SegW-1:0] segments;
        logic [DenW-1:0] digit_enable_n;
    } disp_t;

    function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] digit);
        logic [SegW-1:0] pat;
        unique case (digit)
            4'd0: pat = 8'h48;
            4'd1: pat = 8'h7D;
            4'd2: pat = 8'hC4;
            4'd3: pat = 8'h64;
            4'd4: pat = 8'h71;
            4'd5: pat = 8'h62;
            4'd6: pat = 8'h43;
            4'd7: pat = 8'h7C;
            4'd8: pat = 8'h40;
            4'd9: pat = 8'h70;
            default: pat = 8'h48;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bdadj_display.sv @@
// ----------------------------------------------------------------------------
// bdadj_display
// Converts a duty value to percent, splits it into two decimal digits and
// selects the digit pattern and enables for the current display phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdadj_display (
    input  wire logic [bdadj_pkg::DutyW-1:0] duty,
    input  wire logic                        phase,
    output bdadj_pkg::disp_t                 disp
);
    import bdadj_pkg::*;

    logic [DutyW+7-1:0]  duty_x100;
    logic [PctW-1:0]     pct;
    logic [PctW+11-1:0]  pct_x205;
    logic [DigitW-1:0]   tens;
    logic [PctW-1:0]     tens_x10;
    logic [DigitW-1:0]   units;

    always_comb begin
        duty_x100 = {7'd0, duty} * 15'd100;
        pct       = duty_x100[DutyW+PctW-1:DutyW];
        // A multiply by 205 and a shift by 11 divides by ten exactly below 180.
        pct_x205  = {11'd0, pct} * 18'd205;
        tens      = pct_x205[DigitW+11-1:11];
        tens_x10  = {3'd0, tens} * 7'd10;
        units     = 4'(pct - tens_x10);

        disp.percent        = pct;
        disp.segments       = seg_pattern(phase ? units : tens);
        disp.digit_enable_n = phase ? DenUnits : DenTens;
    end

endmodule

`default_nettype wire

@@ rtl/button_duty_adjust_with_segment_display_unit.sv @@
// ----------------------------------------------------------------------------
// button_duty_adjust_with_segment_display_unit
// Up/down button duty control with lockout debounce and a two-digit
// seven-segment percent display drive.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                        Content
// s_       in   s_tvalid s_tready s_tdata      tdata: up_pressed, down_pressed
//                        s_tuser               tuser: kind (0 poll, 1 tick)
// m_       out  m_tvalid m_tready m_tdata      tdata: duty, percent, segments,
//                                              digit_enable_n
// cfg_     in   cfg_valid cfg_ready cfg_data   debounce_ticks
//
// One beat can be accepted every cycle while m_tready does not hold the output back.
// The result of a beat is registered and appears in the output register in the next cycle.
// A new beat is taken while the output register is empty or being drained.
// Reset clears duty, phase and lockouts and sets debounce_ticks to 6.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_duty_adjust_with_segment_display_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [bdadj_pkg::InDataW-1:0]  s_tdata,   // [0] up_pressed, [1] down_pressed
    input  wire logic                           s_tuser,   // [0] kind
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [bdadj_pkg::OutDataW-1:0] m_tdata,   // [7:0] duty, [14:8] percent,
                                                           // [22:15] segments,
                                                           // [24:23] digit_enable_n
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [bdadj_pkg::DutyW-1:0]    cfg_data
);
    import bdadj_pkg::*;

    logic [DutyW-1:0] debounce_reg;
    logic [DutyW-1:0] duty_reg,      duty_next;
    logic             phase_reg,     phase_next;
    logic [DutyW-1:0] up_lock_reg,   up_lock_next;
    logic [DutyW-1:0] down_lock_reg, down_lock_next;
    logic             m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;

    logic             accept;
    logic             up_fire;
    logic             down_fire;
    logic [DutyW-1:0] duty_up;
    disp_t            disp;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        up_fire        = (s_tuser == KindPoll) && s_tdata[0] && (up_lock_reg == '0);
        down_fire      = (s_tuser == KindPoll) && s_tdata[1] && (down_lock_reg == '0);
        duty_up        = (up_fire && duty_reg != DutyMax) ? duty_reg + 8'd1 : duty_reg;
        duty_next      = (down_fire && duty_up != DutyMin) ? duty_up - 8'd1 : duty_up;
        phase_next     = phase_reg;
        up_lock_next   = up_fire   ? debounce_reg : up_lock_reg;
        down_lock_next = down_fire ? debounce_reg : down_lock_reg;
        if (s_tuser == KindTick) begin
            phase_next     = !phase_reg;
            up_lock_next   = (up_lock_reg != '0)   ? up_lock_reg - 8'd1   : up_lock_reg;
            down_lock_next = (down_lock_reg != '0) ? down_lock_reg - 8'd1 : down_lock_reg;
        end
    end

    bdadj_display u_display (
        .duty  (duty_next),
        .phase (phase_next),
        .disp  (disp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DebounceReset;
            duty_reg      <= '0;
            phase_reg     <= 1'b0;
            up_lock_reg   <= '0;
            down_lock_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_reg <= cfg_data;
            end
            if (accept) begin
                duty_reg      <= duty_next;
                phase_reg     <= phase_next;
                up_lock_reg   <= up_lock_next;
                down_lock_reg <= down_lock_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {7'd0, disp.digit_enable_n, disp.segments, disp.percent, duty_next};
        end
    end

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted beat produced no result");
    a_duty_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(duty_reg))
        else $error("duty changed without an accepted beat");
    a_out_matches_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == duty_reg))
        else $error("result duty differs from state");
    a_enable_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:23] == (phase_reg ? DenUnits : DenTens)))
        else $error("digit enable does not match phase");
`endif

endmodule

`default_nettype wire
